### rtl/lcpd_pkg.sv
// lcpd_pkg: shared types and constants for the line centroid PD steering unit.
// No dependencies; imported by line_centroid_pd_steering_unit.
`default_nettype none

package lcpd_pkg;

    // Frame layout and fixed arithmetic widths
    localparam int SENSOR_COUNT    = 8;
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int WEIGHT_STEP     = 1000;      // weight of sensor i is i*1000
    localparam int QUO_BITS        = 13;        // centroid is below 8192
    localparam int ERR_BITS        = 14;
    localparam int DIFF_BITS       = ERR_BITS + 1;
    localparam int ERR_MIN         = -8192;
    localparam int ERR_MAX         = 8191;
    localparam int GAIN_BITS       = 16;
    localparam int GAIN_FRAC_BITS  = 12;        // Q4.12 gains
    localparam int DUTY_BITS       = 10;
    localparam int DUTY_MAX        = 1023;
    localparam int MASK_BITS       = 4;
    localparam int DB_BITS         = 12;
    localparam int CENTER_BITS     = 13;
    localparam int CNT_BITS        = $clog2(QUO_BITS);

    // Configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BASE_SPEED    = 3'd0,
        REG_PROP_GAIN     = 3'd1,
        REG_DERIV_GAIN    = 3'd2,
        REG_DEAD_BAND     = 3'd3,
        REG_CENTER_OFFSET = 3'd4
    } t_reg_idx;

    // Register reset values
    localparam logic [DUTY_BITS-1:0]   RST_BASE_SPEED    = 10'd800;
    localparam logic [GAIN_BITS-1:0]   RST_PROP_GAIN     = 16'd819;
    localparam logic [GAIN_BITS-1:0]   RST_DERIV_GAIN    = 16'd188;
    localparam logic [DB_BITS-1:0]     RST_DEAD_BAND     = 12'd500;
    localparam logic [CENTER_BITS-1:0] RST_CENTER_OFFSET = 13'd3500;

    // Pin disable masks per steering zone
    localparam logic [MASK_BITS-1:0] MASK_LEFT  = 4'b0110;
    localparam logic [MASK_BITS-1:0] MASK_RIGHT = 4'b1001;
    localparam logic [MASK_BITS-1:0] MASK_FWD   = 4'b0000;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,     // weighted sum, one sensor per cycle
        ST_DIV,     // restoring divide, one quotient bit per cycle
        ST_ERR,     // subtract center offset
        ST_MULP,    // proportional product
        ST_MULD,    // derivative product
        ST_FIN      // truncate, zone select, load output register
    } t_state;

endpackage

`default_nettype wire

### rtl/line_centroid_pd_steering_unit.sv
// line_centroid_pd_steering_unit: centroid of one sensor frame, PD correction, PWM duties.
// Depends on lcpd_pkg (constants, register indexes, sequencer state type).
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  in      | to block  | i_in_valid / o_in_stall | i_sample_0 .. i_sample_7
//  out     | from block| o_out_valid / i_out_stall| duties, pin mask, line error, flag
//  cfg     | to block  | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// A frame runs through 8 multiply-accumulate steps, 13 divide steps, then error,
// two PD products and the final stage; the accumulate steps and both PD products
// share one signed multiplier.
// Reset (synchronous, active low) restores the register defaults and clears
// the previous error. A held result does not block the next input transfer; the final
// stage waits only while the output register is full and the output is stalled.
`default_nettype none

module line_centroid_pd_steering_unit #(
    parameter int SAMPLE_BITS = lcpd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input channel
    input  wire logic                               i_in_valid,
    output      logic                               o_in_stall,
    input  wire logic [SAMPLE_BITS-1:0]             i_sample_0,
    input  wire logic [SAMPLE_BITS-1:0]             i_sample_1,
    input  wire logic [SAMPLE_BITS-1:0]             i_sample_2,
    input  wire logic [SAMPLE_BITS-1:0]             i_sample_3,
    input  wire logic [SAMPLE_BITS-1:0]             i_sample_4,
    input  wire logic [SAMPLE_BITS-1:0]             i_sample_5,
    input  wire logic [SAMPLE_BITS-1:0]             i_sample_6,
    input  wire logic [SAMPLE_BITS-1:0]             i_sample_7,
    // output channel
    output      logic                               o_out_valid,
    input  wire logic                               i_out_stall,
    output      logic [lcpd_pkg::DUTY_BITS-1:0]     o_duty_right_fwd,
    output      logic [lcpd_pkg::DUTY_BITS-1:0]     o_duty_right_rev,
    output      logic [lcpd_pkg::DUTY_BITS-1:0]     o_duty_left_fwd,
    output      logic [lcpd_pkg::DUTY_BITS-1:0]     o_duty_left_rev,
    output      logic [lcpd_pkg::MASK_BITS-1:0]     o_pin_off_mask,
    output      logic signed [lcpd_pkg::ERR_BITS-1:0] o_line_error,
    output      logic                               o_no_signal,
    // configuration
    input  wire logic                               i_cfg_we,
    input  wire logic [lcpd_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [lcpd_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import lcpd_pkg::*;

    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(SENSOR_COUNT);
    localparam int W_BITS     = SUM_BITS + QUO_BITS;     // weighted sum and divisor
    localparam int MUL_A_BITS = GAIN_BITS + 1;
    localparam int MUL_B_BITS = (SAMPLE_BITS + 1 > DIFF_BITS) ? SAMPLE_BITS + 1 : DIFF_BITS;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
    localparam int TERM_BITS  = PROD_BITS + 1;
    localparam int Q_BITS     = TERM_BITS - GAIN_FRAC_BITS;
    localparam int D_BITS     = Q_BITS + 2;

    // configuration registers
    logic [DUTY_BITS-1:0]   r_base;
    logic [GAIN_BITS-1:0]   r_prop;
    logic [GAIN_BITS-1:0]   r_deriv;
    logic [DB_BITS-1:0]     r_db;
    logic [CENTER_BITS-1:0] r_center;

    // sequencer
    t_state                 r_state, n_state;
    logic [CNT_BITS-1:0]    r_cnt;

    // datapath
    logic [SAMPLE_BITS-1:0] r_samp [SENSOR_COUNT];
    logic [SAMPLE_BITS-1:0] w_in   [SENSOR_COUNT];
    logic [QUO_BITS-1:0]    r_wgt;
    logic [W_BITS-1:0]      r_wsum;
    logic [W_BITS-1:0]      r_dvs;
    logic [QUO_BITS-1:0]    r_quo;
    logic                   r_none;
    logic signed [ERR_BITS-1:0]  r_err;
    logic signed [ERR_BITS-1:0]  r_prev;
    logic signed [TERM_BITS-1:0] r_term;

    // output register
    logic                   r_ovld;
    logic [DUTY_BITS-1:0]   r_d1, r_d2, r_d3, r_d4;
    logic [MASK_BITS-1:0]   r_mask;
    logic signed [ERR_BITS-1:0] r_err_out;
    logic                   r_none_out;

    // control decode
    logic w_accept, w_acc, w_div, w_errc, w_mulp, w_muld, w_fin, w_slot_free;
    logic w_acc_last, w_div_last;

    // combinational datapath
    logic signed [MUL_A_BITS-1:0] w_mul_a;
    logic signed [MUL_B_BITS-1:0] w_mul_b;
    logic signed [PROD_BITS-1:0]  w_prod;
    logic signed [DIFF_BITS-1:0]  w_diff;
    logic [W_BITS-1:0]            w_dvs_next;
    logic                         w_ge;
    logic signed [DIFF_BITS-1:0]  w_cdiff;
    logic signed [ERR_BITS-1:0]   w_err_next;
    logic signed [TERM_BITS-1:0]  w_adj;
    logic signed [Q_BITS-1:0]     w_q;
    logic signed [D_BITS-1:0]     w_qx, w_corr, w_duty_s;
    logic [DUTY_BITS-1:0]         w_duty;
    logic signed [DIFF_BITS-1:0]  w_e15, w_db15;
    logic                         w_left, w_right, w_flip;

    assign w_in[0] = i_sample_0;
    assign w_in[1] = i_sample_1;
    assign w_in[2] = i_sample_2;
    assign w_in[3] = i_sample_3;
    assign w_in[4] = i_sample_4;
    assign w_in[5] = i_sample_5;
    assign w_in[6] = i_sample_6;
    assign w_in[7] = i_sample_7;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= RST_BASE_SPEED;
            r_prop   <= RST_PROP_GAIN;
            r_deriv  <= RST_DERIV_GAIN;
            r_db     <= RST_DEAD_BAND;
            r_center <= RST_CENTER_OFFSET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BASE_SPEED:    r_base   <= i_cfg_data[DUTY_BITS-1:0];
                REG_PROP_GAIN:     r_prop   <= i_cfg_data[GAIN_BITS-1:0];
                REG_DERIV_GAIN:    r_deriv  <= i_cfg_data[GAIN_BITS-1:0];
                REG_DEAD_BAND:     r_db     <= i_cfg_data[DB_BITS-1:0];
                REG_CENTER_OFFSET: r_center <= i_cfg_data[CENTER_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign w_slot_free = !r_ovld || !i_out_stall;
    assign w_acc_last  = (r_cnt == CNT_BITS'(SENSOR_COUNT - 1));
    assign w_div_last  = (r_cnt == CNT_BITS'(QUO_BITS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid)   n_state = ST_ACC;
            ST_ACC:  if (w_acc_last)   n_state = ST_DIV;
            ST_DIV:  if (w_div_last)   n_state = ST_ERR;
            ST_ERR:                    n_state = ST_MULP;
            ST_MULP:                   n_state = ST_MULD;
            ST_MULD:                   n_state = ST_FIN;
            ST_FIN:  if (w_slot_free)  n_state = ST_IDLE;
            default:                   n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_accept   = 1'b0;
        w_acc      = 1'b0;
        w_div      = 1'b0;
        w_errc     = 1'b0;
        w_mulp     = 1'b0;
        w_muld     = 1'b0;
        w_fin      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                w_accept   = i_in_valid;
            end
            ST_ACC:  w_acc  = 1'b1;
            ST_DIV:  w_div  = 1'b1;
            ST_ERR:  w_errc = 1'b1;
            ST_MULP: w_mulp = 1'b1;
            ST_MULD: w_muld = 1'b1;
            ST_FIN:  w_fin  = w_slot_free;
            default: ;
        endcase
    end

    // shared multiplier operand select
    assign w_diff = DIFF_BITS'(r_err) - DIFF_BITS'(r_prev);

    always_comb begin
        w_mul_a = MUL_A_BITS'(r_wgt);
        w_mul_b = MUL_B_BITS'(r_samp[0]);
        case (r_state)
            ST_MULP: begin
                w_mul_a = MUL_A_BITS'(r_prop);
                w_mul_b = MUL_B_BITS'(r_err);
            end
            ST_MULD: begin
                w_mul_a = MUL_A_BITS'(r_deriv);
                w_mul_b = MUL_B_BITS'(w_diff);
            end
            default: ;
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // divide step: compare and subtract the aligned divisor
    assign w_dvs_next = r_dvs + (W_BITS'(r_samp[0]) << (QUO_BITS - 1));
    assign w_ge       = (r_wsum >= r_dvs);

    // line error from quotient, clamped to the error range
    always_comb begin
        w_cdiff = DIFF_BITS'(r_quo) - DIFF_BITS'(r_center);
        if (r_none) begin
            w_err_next = '0;
        end else if (w_cdiff < ERR_MIN) begin
            w_err_next = ERR_BITS'(ERR_MIN);
        end else if (w_cdiff > ERR_MAX) begin
            w_err_next = ERR_BITS'(ERR_MAX);
        end else begin
            w_err_next = w_cdiff[ERR_BITS-1:0];
        end
    end

    // PD term truncated toward zero, zone select and duty saturation
    assign w_adj  = r_term + (r_term[TERM_BITS-1] ?
                              TERM_BITS'((1 << GAIN_FRAC_BITS) - 1) : TERM_BITS'(0));
    assign w_q    = w_adj[TERM_BITS-1:GAIN_FRAC_BITS];
    assign w_qx   = D_BITS'(w_q);
    assign w_e15  = DIFF_BITS'(r_err);
    assign w_db15 = DIFF_BITS'(r_db);
    assign w_left  = (w_e15 < -w_db15);
    assign w_right = (w_e15 > w_db15);
    assign w_flip  = w_left || (!w_right && r_err[ERR_BITS-1]);
    assign w_corr  = w_flip ? -w_qx : w_qx;
    assign w_duty_s = w_corr + D_BITS'(r_base);

    always_comb begin
        if (w_duty_s < 0) begin
            w_duty = '0;
        end else if (w_duty_s > DUTY_MAX) begin
            w_duty = DUTY_BITS'(DUTY_MAX);
        end else begin
            w_duty = w_duty_s[DUTY_BITS-1:0];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_prev  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept || (w_acc && w_acc_last)) begin
                r_cnt <= '0;
            end else if (w_acc || w_div) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_fin) begin
                r_prev <= r_err;
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                r_samp[i] <= w_in[i];
            end
            r_wgt  <= '0;
            r_wsum <= '0;
            r_dvs  <= '0;
        end
        // multiply-accumulate one sensor, sample line shifts down
        if (w_acc) begin
            for (int i = 0; i < SENSOR_COUNT - 1; i++) begin
                r_samp[i] <= r_samp[i+1];
            end
            r_wgt  <= r_wgt + QUO_BITS'(WEIGHT_STEP);
            r_wsum <= r_wsum + w_prod[W_BITS-1:0];
            r_dvs  <= w_dvs_next;
            if (w_acc_last) begin
                r_none <= (w_dvs_next == '0);
            end
        end
        // restoring divide, remainder kept in r_wsum
        if (w_div) begin
            if (w_ge) begin
                r_wsum <= r_wsum - r_dvs;
            end
            r_dvs <= r_dvs >> 1;
            r_quo <= {r_quo[QUO_BITS-2:0], w_ge};
        end
        if (w_errc) begin
            r_err <= w_err_next;
        end
        if (w_mulp) begin
            r_term <= TERM_BITS'(w_prod);
        end
        if (w_muld) begin
            r_term <= r_term + TERM_BITS'(w_prod);
        end
        // result register
        if (w_fin) begin
            r_err_out  <= r_err;
            r_none_out <= r_none;
            if (w_left) begin
                r_d1   <= w_duty;
                r_d2   <= '0;
                r_d3   <= '0;
                r_d4   <= w_duty;
                r_mask <= MASK_LEFT;
            end else if (w_right) begin
                r_d1   <= '0;
                r_d2   <= w_duty;
                r_d3   <= w_duty;
                r_d4   <= '0;
                r_mask <= MASK_RIGHT;
            end else begin
                r_d1   <= w_duty;
                r_d2   <= '0;
                r_d3   <= w_duty;
                r_d4   <= '0;
                r_mask <= MASK_FWD;
            end
        end
    end

    assign o_out_valid      = r_ovld;
    assign o_duty_right_fwd = r_d1;
    assign o_duty_right_rev = r_d2;
    assign o_duty_left_fwd  = r_d3;
    assign o_duty_left_rev  = r_d4;
    assign o_pin_off_mask   = r_mask;
    assign o_line_error     = r_err_out;
    assign o_no_signal      = r_none_out;

endmodule

`default_nettype wire
